FILE: rtl/streaming_source_tokenizer_assert.svh
// Assertion macros for the tokenizer's port-level checker.
`ifndef STREAMING_SOURCE_TOKENIZER_ASSERT_SVH
`define STREAMING_SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: rtl/sst_pkg.sv
// Shared types, codes and helpers for the streaming source tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  localparam int unsigned CounterWidth = 32;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);

  // Counter values after reset
  localparam logic [31:0] StartLineReset   = 32'd1;
  localparam logic [31:0] StartColumnReset = 32'd0;

  // Configuration register indexes
  localparam logic CfgStartLine   = 1'b0;
  localparam logic CfgStartColumn = 1'b1;

  // Result event codes
  localparam logic [1:0] EvChar  = 2'd0;
  localparam logic [1:0] EvClose = 2'd1;
  localparam logic [1:0] EvEnd   = 2'd2;
  localparam logic [1:0] EvErr   = 2'd3;

  // Token kinds
  localparam logic [1:0] KindWord = 2'd0;
  localparam logic [1:0] KindInt  = 2'd1;
  localparam logic [1:0] KindStr  = 2'd2;

  // Error codes
  localparam logic ErrUnexpected = 1'b0;
  localparam logic ErrUntermStr  = 1'b1;

  // Character constants
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChUscore  = 8'h5F;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic        first;
    logic [31:0] token_line;
    logic [31:0] token_column;
    logic        error_code;
    logic        last;
  } res_t;

  // One or two results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pkt_t;

  function automatic res_t mk_res(logic [1:0] ev, logic [1:0] kind, logic [7:0] byte_v,
                                  logic first, logic [31:0] line, logic [31:0] col,
                                  logic err);
    res_t r;
    r.event_res    = ev;
    r.kind         = kind;
    r.text_byte    = byte_v;
    r.first        = first;
    r.token_line   = line;
    r.token_column = col;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sst_fifo.sv
// Short result-packet queue between the lexer front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module sst_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire sst_pkg::pkt_t push_pkt_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output sst_pkg::pkt_t      pop_pkt_o
);

  sst_pkg::pkt_t mem_q [sst_pkg::QDepth];

  logic [sst_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sst_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [sst_pkg::QPtrW:0]   count_q, count_d;
  logic push, pop;

  assign push_ready_o = count_q != (sst_pkg::QPtrW+1)'(sst_pkg::QDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_pkt_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sst_front.sv
// Lexer front end: classifies each byte, keeps mode and position counters,
// and builds the result packet for the byte.
`timescale 1ns / 1ps
`default_nettype none
module sst_front #(
  parameter int unsigned COUNTER_WIDTH = sst_pkg::CounterWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    ch_i,
  input  wire logic          is_end_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output logic               push_valid_o,
  input  wire logic          push_ready_i,
  output sst_pkg::pkt_t      push_pkt_o
);

  typedef enum logic [2:0] {
    MdIdle, MdComment, MdWord, MdInt, MdMinus, MdStrOpen, MdStrBody, MdHalt
  } mode_e;

  localparam int unsigned CW = COUNTER_WIDTH;

  mode_e          mode_q, mode_d;
  logic           inner_q, inner_d;
  logic [CW-1:0]  line_q, line_d;
  logic [CW-1:0]  col_q, col_d;
  logic [CW-1:0]  open_q, open_d;

  logic        fire, end_w, adv;
  logic [31:0] line32, col32, open32;

  // plain-byte path: quote, blank or unexpected
  mode_e          pb_mode;
  logic [CW-1:0]  pb_open;
  logic           pb_has;
  sst_pkg::res_t  pb_res;

  // path for a byte seen from idle
  mode_e          ib_mode;
  logic [CW-1:0]  ib_open;
  logic           ib_inner;
  logic           ib_has;
  sst_pkg::res_t  ib_res;

  logic [1:0]     n_res;
  sst_pkg::res_t  r0, r1;

  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign end_w      = is_end_i || (ch_i == sst_pkg::ChNul);
  assign line32     = 32'(line_q);
  assign col32      = 32'(col_q);
  assign open32     = 32'(open_q);

  always_comb begin
    pb_mode = MdHalt;
    pb_open = open_q;
    pb_has  = 1'b0;
    pb_res  = sst_pkg::mk_res(sst_pkg::EvErr, sst_pkg::KindWord, ch_i, 1'b0,
                              line32, col32, sst_pkg::ErrUnexpected);
    if (ch_i == sst_pkg::ChQuote) begin
      pb_mode = MdStrOpen;
      pb_open = col_q + CW'(1);
    end else if (ch_i == sst_pkg::ChSpace || ch_i == sst_pkg::ChTab ||
                 ch_i == sst_pkg::ChNewline) begin
      pb_mode = MdIdle;
    end else begin
      pb_has = 1'b1;
    end
  end

  always_comb begin
    ib_mode  = pb_mode;
    ib_open  = pb_open;
    ib_inner = inner_q;
    ib_has   = pb_has;
    ib_res   = pb_res;
    if (ch_i == sst_pkg::ChHash || ch_i == sst_pkg::ChSemi) begin
      ib_mode = MdComment;
      ib_open = open_q;
      ib_has  = 1'b0;
    end else if (sst_pkg::is_letter(ch_i)) begin
      ib_mode = MdWord;
      ib_open = col_q;
      ib_has  = 1'b1;
      ib_res  = sst_pkg::mk_res(sst_pkg::EvChar, sst_pkg::KindWord, ch_i, 1'b1,
                                line32, col32, 1'b0);
    end else if (ch_i == sst_pkg::ChMinus) begin
      ib_mode = MdMinus;
      ib_open = open_q;
      ib_has  = 1'b0;
    end else if (sst_pkg::is_digit(ch_i)) begin
      ib_mode  = MdInt;
      ib_open  = col_q;
      ib_inner = 1'b0;
      ib_has   = 1'b1;
      ib_res   = sst_pkg::mk_res(sst_pkg::EvChar, sst_pkg::KindInt, ch_i, 1'b1,
                                 line32, col32, 1'b0);
    end
  end

  always_comb begin
    sst_pkg::res_t end_res;
    logic          str_go;
    end_res = sst_pkg::mk_res(sst_pkg::EvEnd, sst_pkg::KindWord, sst_pkg::ChNul, 1'b0,
                              line32, col32, 1'b0);
    str_go  = 1'b0;
    mode_d  = mode_q;
    inner_d = inner_q;
    open_d  = open_q;
    n_res   = 2'd0;
    r0      = end_res;
    r1      = end_res;
    unique case (mode_q)
      MdHalt: begin
        n_res = 2'd0;
      end
      MdComment: begin
        if (end_w) begin
          n_res  = 2'd1;
          mode_d = MdIdle;
        end else if (ch_i == sst_pkg::ChNewline) begin
          mode_d = MdIdle;
        end
      end
      MdWord, MdInt: begin
        if (mode_q == MdWord) begin
          str_go = !end_w && (sst_pkg::is_letter(ch_i) || sst_pkg::is_digit(ch_i) ||
                              ch_i == sst_pkg::ChUscore);
        end else begin
          str_go = !end_w && (sst_pkg::is_digit(ch_i) ||
                              (ch_i == sst_pkg::ChMinus && !inner_q));
        end
        if (str_go) begin
          n_res = 2'd1;
          r0    = sst_pkg::mk_res(sst_pkg::EvChar,
                                  (mode_q == MdWord) ? sst_pkg::KindWord : sst_pkg::KindInt,
                                  ch_i, 1'b0, line32, open32, 1'b0);
          if (ch_i == sst_pkg::ChMinus) begin
            inner_d = 1'b1;
          end
        end else begin
          r0 = sst_pkg::mk_res(sst_pkg::EvClose,
                               (mode_q == MdWord) ? sst_pkg::KindWord : sst_pkg::KindInt,
                               sst_pkg::ChNul, 1'b0, line32, open32, 1'b0);
          if (end_w) begin
            n_res  = 2'd2;
            mode_d = MdIdle;
          end else begin
            // terminating byte is lexed again from idle in the same step
            n_res   = ib_has ? 2'd2 : 2'd1;
            r1      = ib_res;
            mode_d  = ib_mode;
            open_d  = ib_open;
            inner_d = ib_inner;
          end
        end
      end
      MdMinus: begin
        if (end_w) begin
          n_res  = 2'd1;
          mode_d = MdIdle;
        end else if (sst_pkg::is_digit(ch_i)) begin
          n_res   = 2'd2;
          mode_d  = MdInt;
          inner_d = 1'b0;
          open_d  = col_q;
          r0      = sst_pkg::mk_res(sst_pkg::EvChar, sst_pkg::KindInt, sst_pkg::ChMinus,
                                    1'b1, line32, col32, 1'b0);
          r1      = sst_pkg::mk_res(sst_pkg::EvChar, sst_pkg::KindInt, ch_i, 1'b0,
                                    line32, col32, 1'b0);
        end else begin
          n_res  = pb_has ? 2'd1 : 2'd0;
          r0     = pb_res;
          mode_d = pb_mode;
          open_d = pb_open;
        end
      end
      MdStrOpen, MdStrBody: begin
        n_res = 2'd1;
        if (end_w || ch_i == sst_pkg::ChNewline) begin
          r0     = sst_pkg::mk_res(sst_pkg::EvErr, sst_pkg::KindWord,
                                   end_w ? sst_pkg::ChNul : ch_i, 1'b0, line32, open32,
                                   sst_pkg::ErrUntermStr);
          mode_d = MdHalt;
        end else if (ch_i == sst_pkg::ChQuote) begin
          r0     = sst_pkg::mk_res(sst_pkg::EvClose, sst_pkg::KindStr, sst_pkg::ChNul,
                                   1'b0, line32, open32, 1'b0);
          mode_d = MdIdle;
        end else begin
          r0     = sst_pkg::mk_res(sst_pkg::EvChar, sst_pkg::KindStr, ch_i,
                                   mode_q == MdStrOpen, line32, open32, 1'b0);
          mode_d = MdStrBody;
        end
      end
      MdIdle: begin
        if (end_w) begin
          n_res  = 2'd1;
          mode_d = MdIdle;
        end else begin
          n_res   = ib_has ? 2'd1 : 2'd0;
          r0      = ib_res;
          mode_d  = ib_mode;
          open_d  = ib_open;
          inner_d = ib_inner;
        end
      end
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  assign adv = !end_w && mode_q != MdHalt && mode_d != MdHalt;

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (adv) begin
      if (ch_i == sst_pkg::ChNewline) begin
        line_d = line_q + CW'(1);
        col_d  = '0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign push_valid_o   = fire && (n_res != 2'd0);
  assign push_pkt_o.two = (n_res == 2'd2);
  assign push_pkt_o.r0  = r0;
  assign push_pkt_o.r1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MdIdle;
      inner_q <= 1'b0;
      line_q  <= CW'(sst_pkg::StartLineReset);
      col_q   <= CW'(sst_pkg::StartColumnReset);
      open_q  <= '0;
    end else begin
      if (fire) begin
        mode_q  <= mode_d;
        inner_q <= inner_d;
        open_q  <= open_d;
        line_q  <= line_d;
        col_q   <= col_d;
      end
      // the user must write registers only while idle; the block does not enforce it. Writes load the counters
      if (cfg_we_i) begin
        if (cfg_index_i == sst_pkg::CfgStartLine) begin
          line_q <= CW'(cfg_data_i);
        end else begin
          col_q <= CW'(cfg_data_i);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sst_back.sv
// Output stage: splits result packets into single results behind a register.
`timescale 1ns / 1ps
`default_nettype none
module sst_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_valid_i,
  output logic               pop_ready_o,
  input  wire sst_pkg::pkt_t pop_pkt_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sst_pkg::res_t      out_res_o
);

  logic          out_valid_q, out_valid_d;
  logic          pend_valid_q, pend_valid_d;
  sst_pkg::res_t out_res_q, out_res_d;
  sst_pkg::res_t pend_res_q, pend_res_d;
  logic          slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = slot_free && !pend_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    out_res_d    = out_res_q;
    pend_res_d   = pend_res_q;
    if (slot_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = pend_res_q;
        pend_valid_d = 1'b0;
      end else if (pop_valid_i) begin
        out_valid_d  = 1'b1;
        out_res_d    = pop_pkt_i.r0;
        pend_valid_d = pop_pkt_i.two;
        pend_res_d   = pop_pkt_i.r1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    pend_res_q <= pend_res_d;
  end

endmodule
`default_nettype wire

FILE: rtl/streaming_source_tokenizer.sv
// Streaming source tokenizer: top level tying front end, queue and output stage.
//
// Usage: source bytes enter on the in channel (ch_i, is_end_i) with valid/ready;
// a transfer happens when in_valid_i and in_ready_o are both high. Token
// events leave on the out channel, one result per transfer, with last_o on
// the final result caused by a byte. A byte gives zero, one or two results.
// A byte's first result is written into the packet queue and then loaded into the
// output register before it is shown. Throughput: one byte per cycle while bytes
// give at most one result each and the queue is not full; a byte with two results
// holds the single-result output register for both of them.
// The four-entry packet queue absorbs short receiver stalls; when it fills,
// in_ready_o drops until the receiver takes results again.
// Reset: mode idle, line counter 1, column counter 0, queue empty.
// A write on the cfg port loads the line or column counter; write only while
// no byte is in flight. After an error the block takes bytes and drops them
// until reset.
`timescale 1ns / 1ps
`default_nettype none
module streaming_source_tokenizer #(
  parameter int unsigned COUNTER_WIDTH = sst_pkg::CounterWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic [1:0]       kind_o,
  output logic [7:0]       text_byte_o,
  output logic             first_o,
  output logic [31:0]      token_line_o,
  output logic [31:0]      token_column_o,
  output logic             error_code_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic          push_valid, push_ready;
  sst_pkg::pkt_t push_pkt;
  logic          pop_valid, pop_ready;
  sst_pkg::pkt_t pop_pkt;
  sst_pkg::res_t out_res;

  sst_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .is_end_i    (is_end_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_pkt_o  (push_pkt)
  );

  sst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_pkt_i  (push_pkt),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_pkt_o   (pop_pkt)
  );

  sst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_pkt_i  (pop_pkt),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res)
  );

  assign event_res_o    = out_res.event_res;
  assign kind_o         = out_res.kind;
  assign text_byte_o    = out_res.text_byte;
  assign first_o        = out_res.first;
  assign token_line_o   = out_res.token_line;
  assign token_column_o = out_res.token_column;
  assign error_code_o   = out_res.error_code;
  assign last_o         = out_res.last;

endmodule
`default_nettype wire

FILE: rtl/sst_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_source_tokenizer_assert.svh"
module sst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  event_res_o,
  input wire logic [7:0]  text_byte_o,
  input wire logic [31:0] token_column_o,
  input wire logic        error_code_o,
  input wire logic        last_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // a stalled result holds
  `SST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_res_o) && $stable(text_byte_o) && $stable(token_column_o) && $stable(last_o))
  // the second result of a byte follows right after the first
  `SST_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, out_fire && !last_o, out_valid_o)
  // an error halts the block: nothing comes after it
  `SST_ASSERT_NEXT(a_halt_after_err, clk_i, rst_ni, out_fire && event_res_o == sst_pkg::EvErr, !out_valid_o)
  // error code only on error results
  `SST_ASSERT_IMPLY(a_err_code, clk_i, rst_ni, out_valid_o && event_res_o != sst_pkg::EvErr, !error_code_o)

endmodule

bind streaming_source_tokenizer sst_checker u_sst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_res_o   (event_res_o),
  .text_byte_o   (text_byte_o),
  .token_column_o(token_column_o),
  .error_code_o  (error_code_o),
  .last_o        (last_o)
);
`default_nettype wire

FILE: test/token_event_checker.sv
// Token event checker: predicts the tokenizer's results per transfer and compares them.
`timescale 1ns / 1ps
module token_event_checker
  import sst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        ch_i,
  input  logic              is_end_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        event_res_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        text_byte_i,
  input  logic              first_i,
  input  logic [31:0]       token_line_i,
  input  logic [31:0]       token_column_i,
  input  logic              error_code_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef enum logic [2:0] {
    LxIdle, LxComment, LxWord, LxInt, LxMinus, LxStrOpen, LxStrBody, LxHalt
  } lex_mode_e;

  lex_mode_e   lx_mode;
  logic        minus_seen;
  logic [31:0] line_q;
  logic [31:0] col_q;
  logic [31:0] tok_col_q;
  res_t        due_events[$];
  int unsigned errors;

  assign fail_count_o = errors;

  function automatic logic alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic numeral(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void add_event(logic [1:0] ev, logic [1:0] kind, logic [7:0] b,
                                    logic first_char, logic [31:0] col, logic err);
    res_t r;
    r.event_res    = ev;
    r.kind         = kind;
    r.text_byte    = b;
    r.first        = first_char;
    r.token_line   = line_q;
    r.token_column = col;
    r.error_code   = err;
    r.last         = 1'b0;
    due_events.push_back(r);
  endfunction

  // quote, blank or stray byte
  function automatic void take_plain(logic [7:0] b);
    if (b == ChQuote) begin
      lx_mode   = LxStrOpen;
      tok_col_q = col_q + 32'd1;
    end else if (b == ChSpace || b == ChTab || b == ChNewline) begin
      lx_mode = LxIdle;
    end else begin
      add_event(EvErr, KindWord, b, 1'b0, col_q, ErrUnexpected);
      lx_mode = LxHalt;
    end
  endfunction

  function automatic void take_from_idle(logic [7:0] b);
    lx_mode = LxIdle;
    if (b == ChHash || b == ChSemi) begin
      lx_mode = LxComment;
    end else if (alpha(b)) begin
      lx_mode   = LxWord;
      tok_col_q = col_q;
      add_event(EvChar, KindWord, b, 1'b1, tok_col_q, ErrUnexpected);
    end else if (b == ChMinus) begin
      lx_mode = LxMinus;
    end else if (numeral(b)) begin
      lx_mode    = LxInt;
      minus_seen = 1'b0;
      tok_col_q  = col_q;
      add_event(EvChar, KindInt, b, 1'b1, tok_col_q, ErrUnexpected);
    end else begin
      take_plain(b);
    end
  endfunction

  // the byte that ends a word or integer is lexed again from idle
  function automatic void close_token(logic [1:0] kind, logic stop, logic [7:0] b);
    add_event(EvClose, kind, ChNul, 1'b0, tok_col_q, ErrUnexpected);
    lx_mode = LxIdle;
    if (stop) add_event(EvEnd, KindWord, ChNul, 1'b0, col_q, ErrUnexpected);
    else take_from_idle(b);
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic end_bit);
    logic        stop;
    int unsigned n_before;
    stop     = end_bit || b == ChNul;
    n_before = due_events.size();
    if (lx_mode == LxHalt) return;
    case (lx_mode)
      LxComment: begin
        if (stop) begin
          add_event(EvEnd, KindWord, ChNul, 1'b0, col_q, ErrUnexpected);
          lx_mode = LxIdle;
        end else if (b == ChNewline) begin
          lx_mode = LxIdle;
        end
      end
      LxWord: begin
        if (!stop && (alpha(b) || numeral(b) || b == ChUscore))
          add_event(EvChar, KindWord, b, 1'b0, tok_col_q, ErrUnexpected);
        else
          close_token(KindWord, stop, b);
      end
      LxInt: begin
        if (!stop && (numeral(b) || (b == ChMinus && !minus_seen))) begin
          if (b == ChMinus) minus_seen = 1'b1;
          add_event(EvChar, KindInt, b, 1'b0, tok_col_q, ErrUnexpected);
        end else begin
          close_token(KindInt, stop, b);
        end
      end
      LxMinus: begin
        if (stop) begin
          add_event(EvEnd, KindWord, ChNul, 1'b0, col_q, ErrUnexpected);
          lx_mode = LxIdle;
        end else if (numeral(b)) begin
          lx_mode    = LxInt;
          minus_seen = 1'b0;
          tok_col_q  = col_q;
          add_event(EvChar, KindInt, ChMinus, 1'b1, tok_col_q, ErrUnexpected);
          add_event(EvChar, KindInt, b, 1'b0, tok_col_q, ErrUnexpected);
        end else begin
          take_plain(b);
        end
      end
      LxStrOpen, LxStrBody: begin
        if (stop || b == ChNewline) begin
          add_event(EvErr, KindWord, stop ? ChNul : b, 1'b0, tok_col_q, ErrUntermStr);
          lx_mode = LxHalt;
        end else if (b == ChQuote) begin
          add_event(EvClose, KindStr, ChNul, 1'b0, tok_col_q, ErrUnexpected);
          lx_mode = LxIdle;
        end else begin
          add_event(EvChar, KindStr, b, lx_mode == LxStrOpen, tok_col_q, ErrUnexpected);
          lx_mode = LxStrBody;
        end
      end
      default: begin
        if (stop) begin
          add_event(EvEnd, KindWord, ChNul, 1'b0, col_q, ErrUnexpected);
          lx_mode = LxIdle;
        end else begin
          take_from_idle(b);
        end
      end
    endcase
    if (!stop && lx_mode != LxHalt) begin
      if (b == ChNewline) begin
        line_q = line_q + 32'd1;
        col_q  = '0;
      end else begin
        col_q = col_q + 32'd1;
      end
    end
    if (due_events.size() > n_before) due_events[due_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endfunction

  function automatic void compare_result();
    res_t want;
    if (due_events.size() == 0) begin
      $display("%0t: result with none expected, actual event 0x%0h byte 0x%0h",
               $time, event_res_i, text_byte_i);
      errors++;
    end else begin
      want = due_events.pop_front();
      check_field("event_res", 32'(want.event_res), 32'(event_res_i));
      check_field("kind", 32'(want.kind), 32'(kind_i));
      check_field("text_byte", 32'(want.text_byte), 32'(text_byte_i));
      check_field("first", 32'(want.first), 32'(first_i));
      check_field("token_line", want.token_line, token_line_i);
      check_field("token_column", want.token_column, token_column_i);
      check_field("error_code", 32'(want.error_code), 32'(error_code_i));
      check_field("last", 32'(want.last), 32'(last_i));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_mode    = LxIdle;
      minus_seen = 1'b0;
      line_q     = StartLineReset;
      col_q      = StartColumnReset;
      tok_col_q  = '0;
      errors     = 0;
      due_events.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_result();
      if (cfg_we_i) begin
        if (cfg_index_i == CfgStartLine) line_q = cfg_data_i;
        else col_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) lex_byte(ch_i, is_end_i);
      pending_o <= due_events.size();
    end
  end

endmodule

FILE: test/streaming_source_tokenizer_test.sv
// Testbench top: drives source bytes and register writes into the tokenizer.
`timescale 1ns / 1ps
module streaming_source_tokenizer_test;
  import sst_pkg::*;

  typedef enum int unsigned {
    HaltStrayByte, HaltStrayAfterMinus, HaltStrNewline, HaltStrEnd
  } halt_kind_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  src_byte;
  logic        src_end;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  ev;
  logic [1:0]  kind;
  logic [7:0]  text_byte;
  logic        first_char;
  logic [31:0] tok_line;
  logic [31:0] tok_col;
  logic        err_code;
  logic        last_res;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int unsigned fail_count;
  int unsigned pending;

  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          need_break;
  int unsigned byte_count;

  streaming_source_tokenizer u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .ch_i          (src_byte),
    .is_end_i      (src_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .event_res_o   (ev),
    .kind_o        (kind),
    .text_byte_o   (text_byte),
    .first_o       (first_char),
    .token_line_o  (tok_line),
    .token_column_o(tok_col),
    .error_code_o  (err_code),
    .last_o        (last_res),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  token_event_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .ch_i          (src_byte),
    .is_end_i      (src_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .event_res_i   (ev),
    .kind_i        (kind),
    .text_byte_i   (text_byte),
    .first_i       (first_char),
    .token_line_i  (tok_line),
    .token_column_i(tok_col),
    .error_code_i  (err_code),
    .last_i        (last_res),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random stall bursts
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, logic end_bit);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_byte <= b;
    src_end  <= end_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    byte_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all results; bytes without results may still be in the pipe
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return ChSpace;
      1:       return ChTab;
      default: return ChNewline;
    endcase
  endfunction

  // byte that raises an unexpected-character error from idle or after a lone minus
  function automatic logic [7:0] stray_byte(bit after_minus);
    logic [7:0] b;
    bit         ok;
    do begin
      b  = 8'($urandom_range(1, 255));
      ok = !(b inside {["0":"9"], ChQuote, ChSpace, ChTab, ChNewline});
      if (!after_minus)
        ok = ok && !(b inside {["a":"z"], ["A":"Z"], ChHash, ChSemi, ChMinus});
    end while (!ok);
    return b;
  endfunction

  task automatic send_end();
    if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
    else send_byte(ChNul, 1'b0);
  endtask

  task automatic send_string();
    int unsigned len;
    logic [7:0]  b;
    send_byte(ChQuote, 1'b0);
    len = $urandom_range(0, 8);
    repeat (len) begin
      do b = 8'($urandom_range(1, 255));
      while (b == ChNewline || b == ChQuote);
      send_byte(b, 1'b0);
    end
    send_byte(ChQuote, 1'b0);
  endtask

  // word or integer just sent: separate it, or let a quote, comment or end close it
  task automatic finish_token();
    if ($urandom_range(0, 5) == 0) need_break = 1'b1;
    else send_byte(rand_blank(), 1'b0);
  endtask

  // one well-formed piece of source text; never causes an error
  task automatic send_fragment();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    pick       = need_break ? $urandom_range(6, 9) : $urandom_range(0, 11);
    need_break = 1'b0;
    case (pick)
      0, 1, 2: begin
        send_byte(rand_letter(), 1'b0);
        len = $urandom_range(0, 7);
        repeat (len) begin
          case ($urandom_range(0, 2))
            0:       send_byte(rand_letter(), 1'b0);
            1:       send_byte(rand_digit(), 1'b0);
            default: send_byte(ChUscore, 1'b0);
          endcase
        end
        finish_token();
      end
      3, 4, 5: begin
        if ($urandom_range(0, 1)) send_byte(ChMinus, 1'b0);
        repeat ($urandom_range(1, 5)) send_byte(rand_digit(), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_byte(ChMinus, 1'b0);
          repeat ($urandom_range(0, 3)) send_byte(rand_digit(), 1'b0);
        end
        finish_token();
      end
      6, 7: send_string();
      8: begin
        send_byte($urandom_range(0, 1) ? ChHash : ChSemi, 1'b0);
        len = $urandom_range(0, 10);
        repeat (len) begin
          do b = 8'($urandom_range(1, 255));
          while (b == ChNewline);
          send_byte(b, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) send_end();
        else send_byte(ChNewline, 1'b0);
      end
      9:  send_end();
      10: send_byte(rand_blank(), 1'b0);
      default: begin
        // lone minus, dropped
        send_byte(ChMinus, 1'b0);
        case ($urandom_range(0, 4))
          0, 1, 2: send_byte(rand_blank(), 1'b0);
          3:       send_string();
          default: send_end();
        endcase
      end
    endcase
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned target;
    target = byte_count + n;
    while (byte_count < target) send_fragment();
  endtask

  task automatic send_halt();
    halt_kind_e hk;
    hk = halt_kind_e'($urandom_range(0, 3));
    case (hk)
      HaltStrayByte: send_byte(stray_byte(1'b0), 1'b0);
      HaltStrayAfterMinus: begin
        send_byte(ChMinus, 1'b0);
        send_byte(stray_byte(1'b1), 1'b0);
      end
      HaltStrNewline: begin
        send_byte(ChQuote, 1'b0);
        send_byte(rand_letter(), 1'b0);
        send_byte(ChNewline, 1'b0);
      end
      default: begin
        send_byte(ChQuote, 1'b0);
        send_end();
      end
    endcase
    // halted: these are taken and dropped
    repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    src_byte  <= '0;
    src_end   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CfgStartLine;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // words, signed integers with an inner minus, empty and 0xFF strings,
    // comment, dropped minus, and end of input after a word, an integer and a lone minus
    send_text("Az9_ -0-9\"\"\"\377\"#x\n-\tq");
    send_byte(8'hFF, 1'b1);
    send_text("7");
    send_byte(ChNul, 1'b0);
    send_text("-");
    send_byte(ChNul, 1'b1);
    settle();

    // line counter wraps on the first newline, column counter on the first counted byte
    write_reg(CfgStartLine, '1);
    write_reg(CfgStartColumn, '1);
    run_phase(190);
    settle();

    gaps_on  = 1'b0;
    stall_on = 1'b0;
    write_reg(CfgStartLine, '0);
    write_reg(CfgStartColumn, '0);
    run_phase(190);
    settle();

    gaps_on  = 1'b1;
    stall_on = 1'b1;
    write_reg(CfgStartLine, $urandom());
    write_reg(CfgStartColumn, $urandom());
    run_phase(190);
    settle();

    write_reg(CfgStartLine, 32'hFFFF_FFFE);
    write_reg(CfgStartColumn, 32'hFFFF_FFF0);
    run_phase(190);
    settle();

    gaps_on  = 1'b0;
    stall_on = 1'b0;
    write_reg(CfgStartColumn, $urandom());
    write_reg(CfgStartLine, $urandom());
    run_phase(190);
    send_halt();
    settle();

    if (fail_count == 0) begin
      $display("PASS streaming_source_tokenizer");
    end else begin
      $display("FAIL streaming_source_tokenizer");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL streaming_source_tokenizer");
    $finish;
  end

endmodule
